FILE: rtl/core/sector_cache_tag_controller_defines.svh
// ----------------------------------------------------------------------------
// Sector cache tag controller assertion macros
// Shared assertion forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SECTOR_CACHE_TAG_CONTROLLER_DEFINES_SVH
`define SECTOR_CACHE_TAG_CONTROLLER_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define SCTC_ASSERT_IMPL(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define SCTC_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: rtl/core/sctc_pkg.sv
// ----------------------------------------------------------------------------
// Sector cache tag controller package
// Field widths, request codes and the structs shared between the modules.
// ----------------------------------------------------------------------------
package sctc_pkg;

  localparam int FUNC_W    = 2;
  localparam int DEV_W     = 3;
  localparam int SEC_W     = 32;
  localparam int AGE_W     = 32;
  localparam int SLOT_W    = 3;
  localparam int MAX_IDX_W = 6;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 8;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOOKUP = 2'd0,
    FUNC_FILL   = 2'd1,
    FUNC_INVAL  = 2'd2,
    FUNC_FLUSH  = 2'd3
  } func_t;

  typedef struct packed {
    logic                 flush;
    logic                 fill;
    logic                 touch;
    logic                 inval;
    logic [MAX_IDX_W-1:0] idx;
    logic [DEV_W-1:0]     device;
    logic [SEC_W-1:0]     sector;
    logic [AGE_W-1:0]     age;
  } upd_t;

  typedef struct packed {
    logic                 hit;
    logic [MAX_IDX_W-1:0] hit_idx;
    logic                 free;
    logic [MAX_IDX_W-1:0] free_idx;
  } match_t;

endpackage

FILE: rtl/core/sctc_tag_store.sv
// ----------------------------------------------------------------------------
// Sector cache tag store
// Holds the slot entries, compares every tag in parallel and applies updates.
// ----------------------------------------------------------------------------
module sctc_tag_store
  import sctc_pkg::*;
#(
  parameter int SLOTS = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  upd_t             upd,
  input  logic [DEV_W-1:0] lk_device,
  input  logic [SEC_W-1:0] lk_sector,
  output match_t           match,
  output logic [AGE_W-1:0] ages [SLOTS]
);

  localparam int IDX_W = $clog2(SLOTS);

  logic [SLOTS-1:0] valid_r;
  logic [SLOTS-1:0] valid_nxt;
  logic [DEV_W-1:0] device_r [SLOTS];
  logic [SEC_W-1:0] sector_r [SLOTS];
  logic [AGE_W-1:0] age_r    [SLOTS];
  logic [SLOTS-1:0] hit_vec;
  logic [IDX_W-1:0] wr_idx;

  assign wr_idx = upd.idx[IDX_W-1:0];

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      hit_vec[i] = valid_r[i] && (device_r[i] == lk_device) && (sector_r[i] == lk_sector);
      ages[i]    = age_r[i];
    end
  end

  always_comb begin
    match = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        match.hit     = 1'b1;
        match.hit_idx = MAX_IDX_W'(i);
      end
      if (!valid_r[i]) begin
        match.free     = 1'b1;
        match.free_idx = MAX_IDX_W'(i);
      end
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (upd.flush) begin
      valid_nxt = '0;
    end else if (upd.fill) begin
      valid_nxt[wr_idx] = 1'b1;
    end else if (upd.inval) begin
      valid_nxt[wr_idx] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (upd.fill) begin
      device_r[wr_idx] <= upd.device;
      sector_r[wr_idx] <= upd.sector;
    end
    if (upd.fill || upd.touch) begin
      age_r[wr_idx] <= upd.age;
    end
  end

endmodule

FILE: rtl/core/sctc_age_min.sv
// ----------------------------------------------------------------------------
// Sector cache age minimum tree
// Finds the slot with the smallest age, the lowest slot winning on ties.
// ----------------------------------------------------------------------------
module sctc_age_min
  import sctc_pkg::*;
#(
  parameter int SLOTS = 8
) (
  input  logic [AGE_W-1:0] ages [SLOTS],
  output logic [$clog2(SLOTS)-1:0] min_idx
);

  localparam int IDX_W  = $clog2(SLOTS);
  localparam int LEAVES = 1 << IDX_W;
  localparam int NODES  = 2 * LEAVES - 1;

  logic [AGE_W-1:0] node_age [NODES];
  logic [IDX_W-1:0] node_idx [NODES];

  for (genvar k = 0; k < LEAVES; k++) begin : g_leaf
    if (k < SLOTS) begin : g_used
      assign node_age[LEAVES - 1 + k] = ages[k];
    end else begin : g_pad
      assign node_age[LEAVES - 1 + k] = '1;
    end
    assign node_idx[LEAVES - 1 + k] = IDX_W'(k);
  end

  for (genvar n = 0; n < LEAVES - 1; n++) begin : g_node
    logic take_right;
    assign take_right  = node_age[2 * n + 2] < node_age[2 * n + 1];
    assign node_age[n] = take_right ? node_age[2 * n + 2] : node_age[2 * n + 1];
    assign node_idx[n] = take_right ? node_idx[2 * n + 2] : node_idx[2 * n + 1];
  end

  assign min_idx = node_idx[0];

endmodule

FILE: rtl/core/sector_cache_tag_controller.sv
// ----------------------------------------------------------------------------
// Sector cache tag controller
// Tag lookup and replacement control for a fully associative sector cache.
// ----------------------------------------------------------------------------
// Requests arrive on the in_ stream: in_tuser carries the request code
// (lookup, fill, invalidate, flush) and in_tdata the device and sector.
// Every request produces exactly one response on the out_ stream, carrying
// active, hit and the slot that was matched or written.
// A request is registered when accepted, resolved against the tag store
// while held in the input register, and its response is registered as it
// leaves that register. One request per cycle is sustained while out_tready
// is high, as set by the combinational parallel tag compare and age tree.
// When the response register is full and out_tready is low, the request in
// the input register waits and in_tready drops until the response is taken.
// Reset clears the enable, every valid bit, the age counter and both stream
// registers. A write on cfg_we loads the enable from cfg_wdata and clears every entry.
// ----------------------------------------------------------------------------
`include "sector_cache_tag_controller_defines.svh"

module sector_cache_tag_controller
  import sctc_pkg::*;
#(
  parameter int SLOTS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic                  cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // device[2:0], sector[34:3], zero pad
  input  logic [FUNC_W-1:0]     in_tuser,   // func[1:0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // active[0], hit[1], slot[4:2], zero pad
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int EXT_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

  logic             enable_r;
  logic             s1_valid_r;
  logic             s1_valid_nxt;
  func_t            s1_func_r;
  logic [DEV_W-1:0] s1_dev_r;
  logic [SEC_W-1:0] s1_sec_r;
  logic [AGE_W-1:0] age_counter_r;
  logic [AGE_W-1:0] age_counter_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic             res_active_r;
  logic             res_hit_r;
  logic [SLOT_W-1:0] res_slot_r;

  logic              adv;
  logic              in_acc;
  upd_t              upd;
  match_t            match;
  logic [AGE_W-1:0]  ages [SLOTS];
  logic [IDX_W-1:0]  min_idx;
  logic [IDX_W-1:0]  fill_idx;
  logic [IDX_W-1:0]  hit_idx;
  logic [IDX_W-1:0]  res_idx;
  logic [EXT_W-1:0]  res_idx_ext;
  logic              res_active;
  logic              res_hit;
  logic              live;

  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;
  assign in_acc    = in_tvalid && in_tready;
  assign live      = adv && enable_r;

  sctc_tag_store #(.SLOTS(SLOTS)) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .upd       (upd),
    .lk_device (s1_dev_r),
    .lk_sector (s1_sec_r),
    .match     (match),
    .ages      (ages)
  );

  sctc_age_min #(.SLOTS(SLOTS)) u_age_min (
    .ages    (ages),
    .min_idx (min_idx)
  );

  always_comb begin
    hit_idx = match.hit_idx[IDX_W-1:0];
    if (match.hit) begin
      fill_idx = hit_idx;
    end else if (match.free) begin
      fill_idx = match.free_idx[IDX_W-1:0];
    end else begin
      fill_idx = min_idx;
    end
  end

  always_comb begin
    upd        = '0;
    upd.device = s1_dev_r;
    upd.sector = s1_sec_r;
    upd.age    = age_counter_r + AGE_W'(1);
    upd.flush  = cfg_we;
    res_active = enable_r;
    res_hit    = 1'b0;
    res_idx    = '0;
    case (s1_func_r)
      FUNC_LOOKUP: begin
        upd.touch = live && match.hit;
        upd.idx   = MAX_IDX_W'(hit_idx);
        res_hit   = enable_r && match.hit;
        res_idx   = (enable_r && match.hit) ? hit_idx : '0;
      end
      FUNC_FILL: begin
        upd.fill = live;
        upd.idx  = MAX_IDX_W'(fill_idx);
        res_hit  = enable_r && match.hit;
        res_idx  = enable_r ? fill_idx : '0;
      end
      FUNC_INVAL: begin
        upd.inval = live && match.hit;
        upd.idx   = MAX_IDX_W'(hit_idx);
        res_hit   = enable_r && match.hit;
        res_idx   = (enable_r && match.hit) ? hit_idx : '0;
      end
      FUNC_FLUSH: begin
        upd.flush = cfg_we || live;
      end
      default: begin
        upd.flush = cfg_we;
      end
    endcase
    res_idx_ext = EXT_W'(res_idx);
  end

  always_comb begin
    age_counter_nxt = age_counter_r;
    if (upd.fill || upd.touch) begin
      age_counter_nxt = upd.age;
    end
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r      <= 1'b0;
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      age_counter_r <= '0;
    end else begin
      if (cfg_we) begin
        enable_r <= cfg_wdata;
      end
      s1_valid_r    <= s1_valid_nxt;
      out_valid_r   <= out_valid_nxt;
      age_counter_r <= age_counter_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_func_r <= func_t'(in_tuser);
      s1_dev_r  <= in_tdata[DEV_W-1:0];
      s1_sec_r  <= in_tdata[DEV_W+SEC_W-1:DEV_W];
    end
    if (adv) begin
      res_active_r <= res_active;
      res_hit_r    <= res_hit;
      res_slot_r   <= res_idx_ext[SLOT_W-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - SLOT_W - 2){1'b0}}, res_slot_r, res_hit_r, res_active_r};

  `SCTC_ASSERT_IMPL(a_ready_only_on_stall, !in_tready,
    s1_valid_r && out_valid_r && !out_tready, "input stalled without a blocked response")
  `SCTC_ASSERT_NEXT(a_fill_reports_active, live && (s1_func_r == FUNC_FILL),
    out_valid_r && res_active_r, "fill while enabled did not report active")
  `SCTC_ASSERT_NEXT(a_disabled_is_quiet, adv && !enable_r,
    !res_active_r && !res_hit_r && (age_counter_r == $past(age_counter_r)),
    "disabled request changed state or reported activity")
  `SCTC_ASSERT_NEXT(a_age_step, 1'b1,
    (age_counter_r == $past(age_counter_r)) ||
    (age_counter_r == $past(age_counter_r) + AGE_W'(1)),
    "age counter moved by more than one")

endmodule
